// File: src/bmf_pkg.sv
// ----------------------------------------------------------------------------
// bmf_pkg: shared types and constants of the box mean filter
// Sizes, register indexes, controller states and divide reciprocals.
// ----------------------------------------------------------------------------
package bmf_pkg;

    localparam int MAX_COLS_DEF = 1024;
    localparam int MAX_HALF_DEF = 4;

    localparam int PIX_W       = 8;
    localparam int ROWS_LIMIT  = 4096;
    localparam int ROW_W       = 12;
    localparam int NR_W        = 13;
    localparam int HALF_W      = 3;
    localparam int COLS_CFG_W  = 11;
    localparam int CFG_W       = 13;
    localparam int IDX_W       = 2;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = 21;

    localparam logic [HALF_W-1:0]     HALF_RST = 3'd1;
    localparam logic [NR_W-1:0]       ROWS_RST = 13'd512;
    localparam logic [COLS_CFG_W-1:0] COLS_RST = 11'd512;

    typedef enum logic [IDX_W-1:0] {
        REG_HALF  = 2'd0,
        REG_ROWS  = 2'd1,
        REG_COLS  = 2'd2,
        REG_SPARE = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_FLUSH,
        S_SHIFT,
        S_MUL,
        S_OUT
    } state_t;

    typedef struct packed {
        logic clr;
        logic shift;
    } cell_ctl_t;

    // ceil(2^24 / area); exact floor for any window sum of 8-bit pixels
    function automatic logic [RECIP_W-1:0] recip(input logic [HALF_W-1:0] h);
        logic [RECIP_W-1:0] r;
        unique case (h)
            3'd1:    r = 21'd1864136;
            3'd2:    r = 21'd671089;
            3'd3:    r = 21'd342393;
            3'd4:    r = 21'd207127;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: src/bmf_cell.sv
// ----------------------------------------------------------------------------
// bmf_cell: one row accumulator of the window chain
// Sums the pixels of one window row, then hands its sum to the next cell.
// ----------------------------------------------------------------------------
module bmf_cell #(
    parameter int SUM_W = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bmf_pkg::cell_ctl_t    ctl,
    input  logic                  add_en,
    input  logic [7:0]            pix,
    input  logic [SUM_W-1:0]      sum_in,
    output logic [SUM_W-1:0]      sum_out
);
    import bmf_pkg::*;

    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;

    always_comb
    begin
        sum_next = sum_reg;
        priority if (ctl.clr)
            sum_next = '0;
        else if (ctl.shift)
            sum_next = sum_in;
        else if (add_en)
            sum_next = sum_reg + SUM_W'(pix);
        else
            sum_next = sum_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_reg <= '0;
        else
            sum_reg <= sum_next;
    end

    assign sum_out = sum_reg;

endmodule

// File: src/box_mean_filter_clamped.sv
// Box mean filter, replicated borders, 8-bit raster pixels.
// An item with no result returns to idle after its check; an item with a result
// gets one line store read per window pixel after accept, then the row sums walk
// out of the cell chain, then one multiply.
// One item in flight; the output register lets the next item enter meanwhile.
// Reset: positions cleared, registers to defaults; line store is not cleared.
// ----------------------------------------------------------------------------
// box_mean_filter_clamped: streaming box filter top level
// Line store ring, window read sequencer, row-sum cell chain and divider.
// ----------------------------------------------------------------------------
module box_mean_filter_clamped #(
    parameter int MAX_COLS = bmf_pkg::MAX_COLS_DEF,
    parameter int MAX_HALF = bmf_pkg::MAX_HALF_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [7:0] pixel_value
    input  logic                       s_tuser,   // [0] operation
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,   // [7:0] mean_value
    output logic                       m_tlast,   // frame_end
    input  logic                       cfg_we,
    input  logic [bmf_pkg::IDX_W-1:0]  cfg_index,
    input  logic [bmf_pkg::CFG_W-1:0]  cfg_data
);
    import bmf_pkg::*;

    localparam int RING_ROWS = 2 * MAX_HALF + 2;
    localparam int DEPTH     = RING_ROWS * MAX_COLS;
    localparam int AW        = $clog2(DEPTH);
    localparam int RGW       = $clog2(RING_ROWS);
    localparam int CIW       = $clog2(MAX_COLS);
    localparam int NCW       = $clog2(MAX_COLS + 1);
    localparam int CCW       = (NCW > COLS_CFG_W) ? NCW : COLS_CFG_W;
    localparam int WIN       = 2 * MAX_HALF + 1;
    localparam int WW        = $clog2(WIN);
    localparam int RSW       = PIX_W + $clog2(WIN);
    localparam int TSW       = PIX_W + $clog2(WIN * WIN);

    // configuration
    logic [HALF_W-1:0]     half_reg;
    logic [NR_W-1:0]       rows_reg;
    logic [COLS_CFG_W-1:0] cols_reg;
    logic [HALF_W-1:0]     h_eff;
    logic [NR_W-1:0]       nr_eff;
    logic [NCW-1:0]        nc_eff;
    logic [CCW-1:0]        cols_ext;

    // positions
    logic [ROW_W-1:0] in_row_reg, out_row_reg;
    logic [CIW-1:0]   in_col_reg, out_col_reg;
    logic [RGW-1:0]   in_ring_reg, out_ring_reg;
    logic             frame_full_reg;

    state_t state_reg, state_next;

    logic [WW-1:0]  rd_row_reg, rd_col_reg, rd_row_d_reg, shift_cnt_reg;
    logic           rd_valid_reg;
    logic [AW-1:0]  rd_addr, wr_addr;
    logic [7:0]     rd_data_reg;
    logic [7:0]     mem [DEPTH];

    logic [TSW-1:0]           total_reg;
    logic [TSW+RECIP_W-1:0]   prod_reg;
    logic [7:0]               mean_reg;
    logic                     last_reg;
    logic                     m_valid_reg;

    logic        accept, pix_accept, ready_res, read_done, emit, last_pos;
    logic [NR_W:0]  rr;
    logic [NCW:0]   cc;
    cell_ctl_t   ctl;
    logic [RSW-1:0] chain [WIN+1];
    logic [WIN-1:0] add_en;

    // effective register values
    always_comb
    begin
        h_eff = half_reg;
        if (half_reg == '0)
            h_eff = HALF_W'(1);
        else if (half_reg > HALF_W'(MAX_HALF))
            h_eff = HALF_W'(MAX_HALF);
        nr_eff = rows_reg;
        if (rows_reg == '0)
            nr_eff = NR_W'(1);
        else if (rows_reg > NR_W'(ROWS_LIMIT))
            nr_eff = NR_W'(ROWS_LIMIT);
        cols_ext = CCW'(cols_reg);
        if (cols_ext == '0)
            cols_ext = CCW'(1);
        else if (cols_ext > CCW'(MAX_COLS))
            cols_ext = CCW'(MAX_COLS);
        nc_eff = NCW'(cols_ext);
    end

    assign accept     = s_tvalid && s_tready;
    assign pix_accept = accept && !s_tuser;

    // next result ready once its lower-right needed pixel has arrived
    always_comb
    begin
        rr = (NR_W+1)'(out_row_reg) + (NR_W+1)'(h_eff);
        if (rr > (NR_W+1)'(nr_eff - 1'b1))
            rr = (NR_W+1)'(nr_eff - 1'b1);
        cc = (NCW+1)'(out_col_reg) + (NCW+1)'(h_eff);
        if (cc > (NCW+1)'(nc_eff - 1'b1))
            cc = (NCW+1)'(nc_eff - 1'b1);
        ready_res = frame_full_reg
                 || (rr < (NR_W+1)'(in_row_reg))
                 || ((rr == (NR_W+1)'(in_row_reg)) && (cc < (NCW+1)'(in_col_reg)));
    end

    assign read_done = (rd_row_reg == WW'(2 * h_eff)) && (rd_col_reg == WW'(2 * h_eff));
    assign emit      = (state_reg == S_OUT) && (!m_valid_reg || m_tready);
    assign last_pos  = (NR_W'(out_row_reg) == nr_eff - 1'b1)
                    && (NCW'(out_col_reg) == nc_eff - 1'b1);

    // window read address, row and column clamped at the frame edge
    always_comb
    begin
        int t_r;
        int t_c;
        int ring;
        t_r = int'(out_row_reg) + int'(rd_row_reg) - int'(h_eff);
        if (t_r < 0)
            t_r = 0;
        if (t_r > int'(nr_eff) - 1)
            t_r = int'(nr_eff) - 1;
        ring = int'(out_ring_reg) + t_r - int'(out_row_reg);
        if (ring < 0)
            ring = ring + RING_ROWS;
        else if (ring >= RING_ROWS)
            ring = ring - RING_ROWS;
        t_c = int'(out_col_reg) + int'(rd_col_reg) - int'(h_eff);
        if (t_c < 0)
            t_c = 0;
        if (t_c > int'(nc_eff) - 1)
            t_c = int'(nc_eff) - 1;
        rd_addr = AW'(ring * MAX_COLS + t_c);
        wr_addr = AW'(int'(in_ring_reg) * MAX_COLS + int'(in_col_reg));
    end

    always_ff @(posedge clk)
    begin
        if (pix_accept)
            mem[wr_addr] <= s_tdata;
        rd_data_reg <= mem[rd_addr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = S_CHECK;
            S_CHECK: state_next = ready_res ? S_READ : S_IDLE;
            S_READ:  if (read_done) state_next = S_FLUSH;
            S_FLUSH: state_next = S_SHIFT;
            S_SHIFT: if (shift_cnt_reg == WW'(WIN - 1)) state_next = S_MUL;
            S_MUL:   state_next = S_OUT;
            S_OUT:   if (emit) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // controller outputs
    always_comb
    begin
        s_tready  = (state_reg == S_IDLE);
        ctl.clr   = (state_reg == S_CHECK);
        ctl.shift = (state_reg == S_SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_row_reg    <= '0;
            rd_col_reg    <= '0;
            rd_row_d_reg  <= '0;
            rd_valid_reg  <= 1'b0;
            shift_cnt_reg <= '0;
            total_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= (state_reg == S_READ);
            rd_row_d_reg <= rd_row_reg;
            if (state_reg == S_CHECK)
            begin
                rd_row_reg    <= '0;
                rd_col_reg    <= '0;
                shift_cnt_reg <= '0;
                total_reg     <= '0;
            end
            else if (state_reg == S_READ)
            begin
                if (rd_col_reg == WW'(2 * h_eff))
                begin
                    rd_col_reg <= '0;
                    rd_row_reg <= rd_row_reg + 1'b1;
                end
                else
                    rd_col_reg <= rd_col_reg + 1'b1;
            end
            else if (state_reg == S_SHIFT)
            begin
                shift_cnt_reg <= shift_cnt_reg + 1'b1;
                total_reg     <= total_reg + TSW'(chain[WIN]);
            end
        end
    end

    // row-sum cell chain: cell i collects window row i, then sums shift out
    assign chain[0] = '0;
    genvar gi;
    generate
        for (gi = 0; gi < WIN; gi++)
        begin : g_cell
            assign add_en[gi] = rd_valid_reg && (rd_row_d_reg == WW'(gi));
            bmf_cell #(.SUM_W(RSW)) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (ctl),
                .add_en  (add_en[gi]),
                .pix     (rd_data_reg),
                .sum_in  (chain[gi]),
                .sum_out (chain[gi+1])
            );
        end
    endgenerate

    // divide by area through the reciprocal
    always_ff @(posedge clk)
    begin
        if (state_reg == S_MUL)
            prod_reg <= (TSW+RECIP_W)'(total_reg) * (TSW+RECIP_W)'(recip(h_eff));
        if (emit)
        begin
            mean_reg <= prod_reg[RECIP_SHIFT +: 8];
            last_reg <= last_pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (emit)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = mean_reg;
    assign m_tlast  = last_reg;

    // registers and frame positions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg       <= HALF_RST;
            rows_reg       <= ROWS_RST;
            cols_reg       <= COLS_RST;
            in_row_reg     <= '0;
            in_col_reg     <= '0;
            in_ring_reg    <= '0;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
            out_ring_reg   <= '0;
            frame_full_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_HALF:  half_reg <= cfg_data[HALF_W-1:0];
                REG_ROWS:  rows_reg <= cfg_data[NR_W-1:0];
                REG_COLS:  cols_reg <= cfg_data[COLS_CFG_W-1:0];
                REG_SPARE: ;
                default:   ;
            endcase
            in_row_reg     <= '0;
            in_col_reg     <= '0;
            in_ring_reg    <= '0;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
            out_ring_reg   <= '0;
            frame_full_reg <= 1'b0;
        end
        else if (pix_accept)
        begin
            // a new frame drops whatever the old one still had pending
            if (frame_full_reg)
            begin
                out_row_reg  <= '0;
                out_col_reg  <= '0;
                out_ring_reg <= '0;
            end
            if (NCW'(in_col_reg) + 1'b1 >= nc_eff)
            begin
                in_col_reg <= '0;
                if (NR_W'(in_row_reg) + 1'b1 >= nr_eff)
                begin
                    in_row_reg     <= '0;
                    in_ring_reg    <= '0;
                    frame_full_reg <= 1'b1;
                end
                else
                begin
                    in_row_reg     <= in_row_reg + 1'b1;
                    in_ring_reg    <= (in_ring_reg == RGW'(RING_ROWS - 1)) ?
                                      '0 : in_ring_reg + 1'b1;
                    frame_full_reg <= 1'b0;
                end
            end
            else
            begin
                in_col_reg     <= in_col_reg + 1'b1;
                frame_full_reg <= 1'b0;
            end
        end
        else if (emit)
        begin
            if (NCW'(out_col_reg) + 1'b1 >= nc_eff)
            begin
                out_col_reg <= '0;
                if (NR_W'(out_row_reg) + 1'b1 >= nr_eff)
                begin
                    out_row_reg    <= '0;
                    out_ring_reg   <= '0;
                    frame_full_reg <= 1'b0;
                end
                else
                begin
                    out_row_reg  <= out_row_reg + 1'b1;
                    out_ring_reg <= (out_ring_reg == RGW'(RING_ROWS - 1)) ?
                                    '0 : out_ring_reg + 1'b1;
                end
            end
            else
                out_col_reg <= out_col_reg + 1'b1;
        end
    end

    // no window read may be in flight while a new request can enter
    a_idle_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !rd_valid_reg)
        else $error("window read pending while idle");

    // a finished frame waits with the input position at its origin
    a_full_origin: assert property (@(posedge clk) disable iff (!rst_n)
        frame_full_reg |-> (in_row_reg == '0) && (in_col_reg == '0))
        else $error("frame full with input position not at origin");

    // an emitted result shows up on the output the next cycle
    a_emit_shown: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> m_tvalid)
        else $error("emitted result not presented");

endmodule
